// ----- rtl/pwm_timer_setting_calc_defines.svh -----
// Assertion macros shared by the pwm timer setting blocks
`ifndef PWM_TIMER_SETTING_CALC_DEFINES_SVH
`define PWM_TIMER_SETTING_CALC_DEFINES_SVH
`ifndef SYNTH
`define PTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pts check failed");
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pts check failed");
`else
`define PTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/pts_pkg.sv -----
package pts_pkg;
    localparam int unsigned PERIOD_W   = 30;
    localparam int unsigned RES_W      = 16;
    localparam int unsigned CLK_W      = 8;
    localparam int unsigned CHAN_W     = 3;
    localparam int unsigned DUTY_W     = 16;
    localparam int unsigned PRESC_W    = 12;
    localparam int unsigned FIELD_W    = 28;
    localparam int unsigned IDX_W      = 2;
    localparam int unsigned DP_W       = DUTY_W + PERIOD_W;  // duty * period_ns
    localparam int unsigned TICKS_W    = 29;
    localparam int unsigned DIVQ_W     = 13;
    localparam int unsigned DIVK_W     = DIVQ_W + 10;
    localparam int unsigned X_W        = DP_W + CLK_W;
    localparam int unsigned DVD_W      = X_W;
    localparam int unsigned DSR_W      = 32;
    localparam int unsigned NBITS_W    = 6;
    localparam int unsigned NS_PER_US  = 1000;
    localparam logic [TICKS_W-1:0] PERIOD_FLOOR = 29'd3;
    localparam logic [PRESC_W-1:0] PRESCALE_MAX = 12'hFFF;
    localparam logic [FIELD_W-1:0] FIELD_MAX    = 28'hFFF_FFFF;

    // ticks = (period_ns / 1000) * clock + ((period_ns % 1000) * clock) / 1000
    localparam int unsigned KILO_W       = 21;
    localparam int unsigned PREM_W       = 10;
    localparam int unsigned PREMC_W      = PREM_W + CLK_W;
    localparam int unsigned PREMC_Q_W    = 9;
    // exact reciprocals of 1000 for 30-bit and 18-bit dividends
    localparam int unsigned RCP_KILO_W   = 31;
    localparam int unsigned RCP_KILO_SH  = 40;
    localparam int unsigned KILO_PROD_W  = PERIOD_W + RCP_KILO_W;
    localparam logic [RCP_KILO_W-1:0] RCP_KILO = 31'd1099511628;
    localparam int unsigned RCP_PREMC_W  = 19;
    localparam int unsigned RCP_PREMC_SH = 28;
    localparam int unsigned PREMC_PROD_W = PREMC_W + RCP_PREMC_W;
    localparam logic [RCP_PREMC_W-1:0] RCP_PREMC = 19'd268436;
    // exact reciprocal of the 16-bit counter maximum (0xFFFF) for 29-bit ticks;
    // ticks never reach the 32-bit maximum, so that quotient is zero
    localparam int unsigned RCP_NARROW_W  = 30;
    localparam int unsigned RCP_NARROW_SH = 45;
    localparam int unsigned DIVQ_PROD_W   = TICKS_W + RCP_NARROW_W;
    localparam logic [RCP_NARROW_W-1:0] RCP_NARROW = 30'd536879105;

    localparam logic [2:0] REG_PERIOD  = 3'd0;
    localparam logic [2:0] REG_RES     = 3'd1;
    localparam logic [2:0] REG_CLOCK   = 3'd2;
    localparam logic [2:0] REG_WIDE    = 3'd3;
    localparam logic [2:0] REG_CHANNEL = 3'd4;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ns;
        logic [DP_W-1:0]     dp;
        logic [RES_W-1:0]    res;
        logic [CLK_W-1:0]    clk_mhz;
        logic                wide;
        logic [IDX_W-1:0]    chan_idx;
    } t_item;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DSR_W-1:0]   divisor;
        logic [NBITS_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quot;
    } t_div_rsp;
endpackage

// ----- rtl/pts_front.sv -----
module pts_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pts_pkg::DUTY_W-1:0]    i_duty,
    input  logic [pts_pkg::PERIOD_W-1:0]  i_period_ns,
    input  logic [pts_pkg::RES_W-1:0]     i_duty_resolution,
    input  logic [pts_pkg::CLK_W-1:0]     i_clock_mhz,
    input  logic                          i_wide_counter,
    input  logic [pts_pkg::CHAN_W-1:0]    i_channel_number,
    output logic                          o_push,
    output pts_pkg::t_item                o_item,
    input  logic                          i_full
);
    import pts_pkg::*;

    logic  r_v;
    t_item r_item;
    logic  accept;
    logic  [CHAN_W-1:0] chan_m1;

    assign o_stall = r_v && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_v && !i_full;
    assign o_item  = r_item;
    assign chan_m1 = i_channel_number - CHAN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= accept || (r_v && i_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.period_ns <= i_period_ns;
            r_item.dp        <= DP_W'(i_duty) * DP_W'(i_period_ns);
            // zero resolution counts as one
            r_item.res       <= (i_duty_resolution == '0) ? RES_W'(1) : i_duty_resolution;
            r_item.clk_mhz   <= i_clock_mhz;
            r_item.wide      <= i_wide_counter;
            r_item.chan_idx  <= chan_m1[IDX_W-1:0];
        end
    end
endmodule

// ----- rtl/pts_fifo.sv -----
`include "pwm_timer_setting_calc_defines.svh"
module pts_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pts_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pts_pkg::t_item o_item
);
    import pts_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `PTS_ASSERT_SAME(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `PTS_ASSERT_SAME(a_fifo_no_ovf, i_clk, i_rst_n, i_push, !o_full)
    `PTS_ASSERT_SAME(a_fifo_no_udf, i_clk, i_rst_n, i_pop, o_valid)
endmodule

// ----- rtl/pts_div.sv -----
module pts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pts_pkg::t_div_req i_req,
    output pts_pkg::t_div_rsp o_rsp
);
    import pts_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [NBITS_W-1:0] r_cnt;
    logic [DVD_W-1:0]   r_dvd;
    logic [DSR_W-1:0]   r_dsr;
    logic [DSR_W-1:0]   r_rem;
    logic [DVD_W-1:0]   r_quot;
    logic [DSR_W:0]     trial;
    logic               ge;
    logic [DSR_W:0]     diff;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign ge    = (trial >= {1'b0, r_dsr});
    assign diff  = trial - {1'b0, r_dsr};

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - NBITS_W'(1);
                if (r_cnt == NBITS_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, dividend enters MSB first
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_dvd  <= i_req.dividend;
            r_dsr  <= i_req.divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem  <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            r_quot <= {r_quot[DVD_W-2:0], ge};
        end
    end
endmodule

// ----- rtl/pts_back.sv -----
`include "pwm_timer_setting_calc_defines.svh"
module pts_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  pts_pkg::t_item                i_item,
    output logic                          o_pop,
    output pts_pkg::t_div_req             o_div_req,
    input  pts_pkg::t_div_rsp             i_div_rsp,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pts_pkg::PRESC_W-1:0]   o_prescale_value,
    output logic [pts_pkg::FIELD_W-1:0]   o_reload_value,
    output logic [pts_pkg::FIELD_W-1:0]   o_compare_value,
    output logic [pts_pkg::IDX_W-1:0]     o_channel_index
);
    import pts_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_KILO   = 4'd1;
    localparam logic [3:0] S_SPLIT  = 4'd2;
    localparam logic [3:0] S_REMCLK = 4'd3;
    localparam logic [3:0] S_TICKS  = 4'd4;
    localparam logic [3:0] S_DIVQ   = 4'd5;
    localparam logic [3:0] S_PSTART = 4'd6;
    localparam logic [3:0] S_PER    = 4'd7;
    localparam logic [3:0] S_PNS    = 4'd8;
    localparam logic [3:0] S_XST    = 4'd9;
    localparam logic [3:0] S_PUL    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]          r_state, n_state;
    t_item               r_item;
    logic [KILO_W-1:0]   r_kilo;
    logic [PREM_W-1:0]   r_prem;
    logic [TICKS_W-1:0]  r_kclk;
    logic [PREMC_W-1:0]  r_premc;
    logic [TICKS_W-1:0]  r_ticks;
    logic [DIVQ_W-1:0]   r_div;
    logic [DIVK_W-1:0]   r_divk;
    logic [TICKS_W-1:0]  r_per;
    logic [X_W-1:0]      r_x;
    logic [X_W-1:0]      r_pul;
    logic                r_ovalid;
    logic [PRESC_W-1:0]  r_presc;
    logic [FIELD_W-1:0]  r_reload;
    logic [FIELD_W-1:0]  r_cmp;
    logic [IDX_W-1:0]    r_idx;

    logic [KILO_PROD_W-1:0]  kilo_prod;
    logic [PERIOD_W-1:0]     prem_full;
    logic [PREMC_PROD_W-1:0] premc_prod;
    logic [DIVQ_PROD_W-1:0]  divq_prod;
    logic [DIVQ_W-1:0]   div_next;
    logic [TICKS_W-1:0]  per_fl;
    logic [X_W-1:0]      cmp_raw;
    logic [TICKS_W-1:0]  reload_raw;
    logic [DIVQ_W-1:0]   presc_raw;
    logic                out_load;
    logic                waiting;

    assign kilo_prod  = KILO_PROD_W'(r_item.period_ns) * KILO_PROD_W'(RCP_KILO);
    assign prem_full  = r_item.period_ns - PERIOD_W'(r_kilo) * PERIOD_W'(NS_PER_US);
    assign premc_prod = PREMC_PROD_W'(r_premc) * PREMC_PROD_W'(RCP_PREMC);
    assign divq_prod  = DIVQ_PROD_W'(r_ticks) * DIVQ_PROD_W'(RCP_NARROW);
    assign div_next   = r_item.wide ? DIVQ_W'(1)
                                    : divq_prod[RCP_NARROW_SH +: DIVQ_W] + DIVQ_W'(1);
    assign per_fl   = (r_per < PERIOD_FLOOR) ? PERIOD_FLOOR : r_per;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign o_pop    = (r_state == S_IDLE) && i_item_valid;
    assign waiting  = (r_state == S_PER) || (r_state == S_PNS) || (r_state == S_PUL);

    always_comb begin
        n_state           = r_state;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.divisor  = '0;
        o_div_req.nbits    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = S_KILO;
                end
            end
            S_KILO:   n_state = S_SPLIT;
            S_SPLIT:  n_state = S_REMCLK;
            S_REMCLK: n_state = S_TICKS;
            S_TICKS:  n_state = S_DIVQ;
            S_DIVQ:   n_state = S_PSTART;
            S_PSTART: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = {r_ticks, (DVD_W - TICKS_W)'(0)};
                o_div_req.divisor  = DSR_W'(r_div);
                o_div_req.nbits    = NBITS_W'(TICKS_W);
                n_state            = S_PER;
            end
            S_PER: begin
                if (i_div_rsp.done) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = {r_item.dp, (DVD_W - DP_W)'(0)};
                    o_div_req.divisor  = DSR_W'(r_item.res);
                    o_div_req.nbits    = NBITS_W'(DP_W);
                    n_state            = S_PNS;
                end
            end
            S_PNS: begin
                if (i_div_rsp.done) begin
                    n_state = S_XST;
                end
            end
            S_XST: begin
                // pulse = pulse_ns * clock_mhz / (divider * 1000)
                o_div_req.start    = 1'b1;
                o_div_req.dividend = r_x;
                o_div_req.divisor  = DSR_W'(r_divk);
                o_div_req.nbits    = NBITS_W'(X_W);
                n_state            = S_PUL;
            end
            S_PUL: begin
                if (i_div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        presc_raw  = r_div - DIVQ_W'(1);
        reload_raw = per_fl - TICKS_W'(1);
        priority if (r_pul == '0) begin
            cmp_raw = '0;
        end else if (r_pul >= X_W'(per_fl)) begin
            cmp_raw = X_W'(per_fl);
        end else begin
            cmp_raw = r_pul - X_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_KILO) begin
            r_kilo <= kilo_prod[RCP_KILO_SH +: KILO_W];
        end
        if (r_state == S_SPLIT) begin
            r_prem <= prem_full[PREM_W-1:0];
            r_kclk <= TICKS_W'(r_kilo) * TICKS_W'(r_item.clk_mhz);
        end
        if (r_state == S_REMCLK) begin
            r_premc <= PREMC_W'(r_prem) * PREMC_W'(r_item.clk_mhz);
        end
        if (r_state == S_TICKS) begin
            r_ticks <= r_kclk + TICKS_W'(premc_prod[RCP_PREMC_SH +: PREMC_Q_W]);
        end
        if (r_state == S_DIVQ) begin
            r_div <= div_next;
        end
        if (r_state == S_PSTART) begin
            r_divk <= DIVK_W'(r_div) * DIVK_W'(NS_PER_US);
        end
        if (r_state == S_PER && i_div_rsp.done) begin
            r_per <= i_div_rsp.quot[TICKS_W-1:0];
        end
        if (r_state == S_PNS && i_div_rsp.done) begin
            r_x <= X_W'(i_div_rsp.quot[DP_W-1:0]) * X_W'(r_item.clk_mhz);
        end
        if (r_state == S_PUL && i_div_rsp.done) begin
            r_pul <= i_div_rsp.quot;
        end
        if (out_load) begin
            r_presc  <= (presc_raw > DIVQ_W'(PRESCALE_MAX)) ? PRESCALE_MAX
                                                            : presc_raw[PRESC_W-1:0];
            r_reload <= (reload_raw > TICKS_W'(FIELD_MAX)) ? FIELD_MAX
                                                           : reload_raw[FIELD_W-1:0];
            r_cmp    <= (cmp_raw > X_W'(FIELD_MAX)) ? FIELD_MAX : cmp_raw[FIELD_W-1:0];
            r_idx    <= r_item.chan_idx;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_prescale_value = r_presc;
    assign o_reload_value   = r_reload;
    assign o_compare_value  = r_cmp;
    assign o_channel_index  = r_idx;

    `PTS_ASSERT_SAME(a_idle_div_free, i_clk, i_rst_n, r_state == S_IDLE, !i_div_rsp.busy)
    `PTS_ASSERT_SAME(a_done_expected, i_clk, i_rst_n, i_div_rsp.done, waiting)
    `PTS_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, out_load, o_valid)
endmodule

// ----- rtl/pwm_timer_setting_calc.sv -----
// The back computes one word at a time on the shared radix-2 divider
// (29 + 46 + 54 quotient bits per word) and takes the next word only when idle.
// A small queue lets the front take the next words while the back computes.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
module pwm_timer_setting_calc #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pts_pkg::DUTY_W-1:0]    i_duty,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pts_pkg::PRESC_W-1:0]   o_prescale_value,
    output logic [pts_pkg::FIELD_W-1:0]   o_reload_value,
    output logic [pts_pkg::FIELD_W-1:0]   o_compare_value,
    output logic [pts_pkg::IDX_W-1:0]     o_channel_index
);
    import pts_pkg::*;

    logic [PERIOD_W-1:0] r_period_ns;
    logic [RES_W-1:0]    r_duty_resolution;
    logic [CLK_W-1:0]    r_clock_mhz;
    logic                r_wide_counter;
    logic [CHAN_W-1:0]   r_channel_number;
    logic [2:0]          reg_idx;
    logic                wr_en;

    logic     push;
    logic     full;
    t_item    front_item;
    logic     q_valid;
    t_item    q_item;
    logic     pop;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ns       <= PERIOD_W'(1000000);
            r_duty_resolution <= RES_W'(100);
            r_clock_mhz       <= CLK_W'(24);
            r_wide_counter    <= 1'b0;
            r_channel_number  <= CHAN_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PERIOD:  r_period_ns       <= pwdata[PERIOD_W-1:0];
                REG_RES:     r_duty_resolution <= pwdata[RES_W-1:0];
                REG_CLOCK:   r_clock_mhz       <= pwdata[CLK_W-1:0];
                REG_WIDE:    r_wide_counter    <= pwdata[0];
                REG_CHANNEL: r_channel_number  <= pwdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PERIOD:  prdata = 32'(r_period_ns);
            REG_RES:     prdata = 32'(r_duty_resolution);
            REG_CLOCK:   prdata = 32'(r_clock_mhz);
            REG_WIDE:    prdata = 32'(r_wide_counter);
            REG_CHANNEL: prdata = 32'(r_channel_number);
            default:     prdata = '0;
        endcase
    end

    pts_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_duty            (i_duty),
        .i_period_ns       (r_period_ns),
        .i_duty_resolution (r_duty_resolution),
        .i_clock_mhz       (r_clock_mhz),
        .i_wide_counter    (r_wide_counter),
        .i_channel_number  (r_channel_number),
        .o_push            (push),
        .o_item            (front_item),
        .i_full            (full)
    );

    pts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pts_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (q_valid),
        .i_item           (q_item),
        .o_pop            (pop),
        .o_div_req        (div_req),
        .i_div_rsp        (div_rsp),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_prescale_value (o_prescale_value),
        .o_reload_value   (o_reload_value),
        .o_compare_value  (o_compare_value),
        .o_channel_index  (o_channel_index)
    );
endmodule
